// ----- hdl/acr_pkg.sv -----
// acr_pkg: shared widths, register indexes, bus types and the square root step
// for the antialiased circle overlay pipeline
// no dependencies

package acr_pkg;

    localparam int FracBits      = 4;
    localparam int WBits         = 8;
    localparam int FixW          = 16;
    localparam int CoordW        = FixW - FracBits;
    localparam int ChanW         = 8;
    localparam int FracMask      = (1 << FracBits) - 1;

    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 16;

    localparam logic [CfgIdxW-1:0] CfgCenterX    = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgCenterY    = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgRadius     = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgColorBlue  = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgColorGreen = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgColorRed   = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgFillMode   = 3'd6;

    localparam int SqW           = 2 * FixW;
    localparam int SumW          = SqW + 1;
    localparam int ShiftW        = 2 * (WBits - FracBits);
    localparam int RawRadW       = SumW + ShiftW;
    localparam int RadW          = RawRadW + (RawRadW % 2);
    localparam int RootW         = RadW / 2;
    localparam int RemW          = RootW + 3;
    localparam int StepsPerStage = 3;
    localparam int SqrtStages    = (RootW + StepsPerStage - 1) / StepsPerStage;

    localparam int RrW           = FixW + WBits - FracBits;
    localparam int OneW          = 1 << WBits;
    localparam int VW            = WBits + 1;
    localparam int AccW          = VW + ChanW + 1;

    localparam int FrontStages   = 4;
    localparam int BlendStages   = 3;
    localparam int Latency       = FrontStages + SqrtStages + BlendStages;

    typedef struct packed {
        logic [FixW-1:0]  center_x;
        logic [FixW-1:0]  center_y;
        logic [FixW-1:0]  radius;
        logic [ChanW-1:0] color_blue;
        logic [ChanW-1:0] color_green;
        logic [ChanW-1:0] color_red;
        logic             fill_mode;
    } t_cfg;

    typedef struct packed {
        logic             in_box;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] red;
    } t_side;

    typedef struct packed {
        logic            vld;
        t_side           side;
        logic [RadW-1:0] rad;
    } t_rad_bus;

    typedef struct packed {
        logic             vld;
        t_side            side;
        logic [RootW-1:0] root;
    } t_root_bus;

    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
    } t_sq_state;

    // one restoring square root digit
    function automatic t_sq_state sqrt_step(t_sq_state s, logic [1:0] pair);
        t_sq_state       o;
        logic [RemW-1:0] acc;
        logic [RemW-1:0] trial;
        acc   = {s.rem[RemW-3:0], pair};
        trial = {{(RemW-RootW-2){1'b0}}, s.root, 2'b01};
        if (acc >= trial) begin
            o.rem  = acc - trial;
            o.root = {s.root[RootW-2:0], 1'b1};
        end else begin
            o.rem  = acc;
            o.root = {s.root[RootW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ----- hdl/acr_front.sv -----
// acr_front: bounding box test, axis distances, squares and radicand
// depends on acr_pkg

module acr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [acr_pkg::CoordW-1:0]  i_pixel_x,
    input  logic [acr_pkg::CoordW-1:0]  i_pixel_y,
    input  logic [acr_pkg::ChanW-1:0]   i_in_blue,
    input  logic [acr_pkg::ChanW-1:0]   i_in_green,
    input  logic [acr_pkg::ChanW-1:0]   i_in_red,
    input  acr_pkg::t_cfg               i_cfg,
    output acr_pkg::t_rad_bus           o_bus
);

    localparam int HiW = acr_pkg::FixW + 2 - acr_pkg::FracBits;

    function automatic logic in_span(logic [acr_pkg::CoordW-1:0] p,
                                     logic [acr_pkg::FixW-1:0] c,
                                     logic [acr_pkg::FixW-1:0] r);
        logic [acr_pkg::FixW:0]     lo_fx;
        logic [acr_pkg::FixW:0]     hi_fx;
        logic [acr_pkg::FixW+1:0]   hi_rnd;
        logic [acr_pkg::CoordW-1:0] lo;
        logic [HiW-1:0]             hi;
        lo_fx  = {1'b0, c} - {1'b0, r};
        lo     = lo_fx[acr_pkg::FixW] ? '0 : lo_fx[acr_pkg::FixW-1:acr_pkg::FracBits];
        hi_fx  = {1'b0, c} + {1'b0, r};
        hi_rnd = {1'b0, hi_fx} + (acr_pkg::FixW+2)'(acr_pkg::FracMask);
        hi     = hi_rnd[acr_pkg::FixW+1:acr_pkg::FracBits];
        return (p >= lo) && (HiW'(p) <= hi);
    endfunction

    function automatic logic [acr_pkg::FixW-1:0] abs_diff(logic [acr_pkg::CoordW-1:0] p,
                                                          logic [acr_pkg::FixW-1:0] c);
        logic [acr_pkg::FixW-1:0] a;
        a = {p, {acr_pkg::FracBits{1'b0}}};
        return (a >= c) ? a - c : c - a;
    endfunction

    logic                       r_s1_vld;
    logic [acr_pkg::CoordW-1:0] r_s1_x;
    logic [acr_pkg::CoordW-1:0] r_s1_y;
    acr_pkg::t_side             r_s1_side;

    logic                       r_s2_vld;
    acr_pkg::t_side             r_s2_side;
    logic [acr_pkg::FixW-1:0]   r_s2_dx;
    logic [acr_pkg::FixW-1:0]   r_s2_dy;

    logic                       r_s3_vld;
    acr_pkg::t_side             r_s3_side;
    logic [acr_pkg::SqW-1:0]    r_s3_sqx;
    logic [acr_pkg::SqW-1:0]    r_s3_sqy;

    logic                       r_s4_vld;
    acr_pkg::t_side             r_s4_side;
    logic [acr_pkg::RadW-1:0]   r_s4_rad;

    acr_pkg::t_side             n_s2_side;
    logic [acr_pkg::SumW-1:0]   n_sum;

    always_comb begin
        n_s2_side        = r_s1_side;
        n_s2_side.in_box = in_span(r_s1_x, i_cfg.center_x, i_cfg.radius)
                        && in_span(r_s1_y, i_cfg.center_y, i_cfg.radius);
        n_sum            = acr_pkg::SumW'(r_s3_sqx) + acr_pkg::SumW'(r_s3_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x           <= i_pixel_x;
        r_s1_y           <= i_pixel_y;
        r_s1_side.in_box <= 1'b0;
        r_s1_side.blue   <= i_in_blue;
        r_s1_side.green  <= i_in_green;
        r_s1_side.red    <= i_in_red;

        r_s2_side <= n_s2_side;
        r_s2_dx   <= abs_diff(r_s1_x, i_cfg.center_x);
        r_s2_dy   <= abs_diff(r_s1_y, i_cfg.center_y);

        r_s3_side <= r_s2_side;
        r_s3_sqx  <= acr_pkg::SqW'(r_s2_dx) * acr_pkg::SqW'(r_s2_dx);
        r_s3_sqy  <= acr_pkg::SqW'(r_s2_dy) * acr_pkg::SqW'(r_s2_dy);

        r_s4_side <= r_s3_side;
        r_s4_rad  <= acr_pkg::RadW'({n_sum, {acr_pkg::ShiftW{1'b0}}});
    end

    assign o_bus.vld  = r_s4_vld;
    assign o_bus.side = r_s4_side;
    assign o_bus.rad  = r_s4_rad;

endmodule

// ----- hdl/acr_sqrt.sv -----
// acr_sqrt: pipelined integer square root, a few digits per stage
// depends on acr_pkg

module acr_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acr_pkg::t_rad_bus  i_bus,
    output acr_pkg::t_root_bus o_bus
);

    localparam int Last = acr_pkg::SqrtStages - 1;

    logic                     r_vld  [acr_pkg::SqrtStages];
    acr_pkg::t_side           r_side [acr_pkg::SqrtStages];
    acr_pkg::t_sq_state       r_st   [acr_pkg::SqrtStages];
    logic [acr_pkg::RadW-1:0] r_rad  [acr_pkg::SqrtStages];

    for (genvar s = 0; s < acr_pkg::SqrtStages; s++) begin : g_stage
        logic                     stage_vld;
        acr_pkg::t_side           stage_side;
        acr_pkg::t_sq_state       stage_st;
        logic [acr_pkg::RadW-1:0] stage_rad;
        acr_pkg::t_sq_state       n_st;
        logic [acr_pkg::RadW-1:0] n_rad;

        if (s == 0) begin : g_first
            assign stage_vld  = i_bus.vld;
            assign stage_side = i_bus.side;
            assign stage_st   = '0;
            assign stage_rad  = i_bus.rad;
        end else begin : g_next
            assign stage_vld  = r_vld[s-1];
            assign stage_side = r_side[s-1];
            assign stage_st   = r_st[s-1];
            assign stage_rad  = r_rad[s-1];
        end

        always_comb begin
            n_st  = stage_st;
            n_rad = stage_rad;
            for (int k = 0; k < acr_pkg::StepsPerStage; k++) begin
                if (s * acr_pkg::StepsPerStage + k < acr_pkg::RootW) begin
                    n_st  = acr_pkg::sqrt_step(n_st, n_rad[acr_pkg::RadW-1 -: 2]);
                    n_rad = {n_rad[acr_pkg::RadW-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= stage_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[s] <= stage_side;
            r_st[s]   <= n_st;
            r_rad[s]  <= n_rad;
        end
    end

    assign o_bus.vld  = r_vld[Last];
    assign o_bus.side = r_side[Last];
    assign o_bus.root = r_st[Last].root;

endmodule

// ----- hdl/acr_blend.sv -----
// acr_blend: edge weight from distance and radius, colour blend, output register
// depends on acr_pkg

module acr_blend (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  acr_pkg::t_root_bus        i_bus,
    input  acr_pkg::t_cfg             i_cfg,
    output logic                      o_done,
    output logic [acr_pkg::ChanW-1:0] o_out_blue,
    output logic [acr_pkg::ChanW-1:0] o_out_green,
    output logic [acr_pkg::ChanW-1:0] o_out_red
);

    function automatic logic [acr_pkg::AccW-1:0] mix(logic [acr_pkg::VW-1:0] v,
                                                     logic [acr_pkg::ChanW-1:0] pix,
                                                     logic [acr_pkg::ChanW-1:0] col);
        logic [acr_pkg::VW-1:0] w;
        w = acr_pkg::VW'(acr_pkg::OneW) - v;
        return acr_pkg::AccW'(v) * acr_pkg::AccW'(pix)
             + acr_pkg::AccW'(w) * acr_pkg::AccW'(col)
             + acr_pkg::AccW'(acr_pkg::OneW / 2);
    endfunction

    function automatic logic [acr_pkg::ChanW-1:0] round_sat(logic [acr_pkg::AccW-1:0] acc);
        logic [acr_pkg::AccW-acr_pkg::WBits-1:0] s;
        s = acc[acr_pkg::AccW-1:acr_pkg::WBits];
        return (s > (acr_pkg::AccW-acr_pkg::WBits)'(255)) ? 8'hff : s[acr_pkg::ChanW-1:0];
    endfunction

    logic                       r_b1_vld;
    logic                       r_b1_draw;
    logic [acr_pkg::VW-1:0]     r_b1_v;
    acr_pkg::t_side             r_b1_side;

    logic                       r_b2_vld;
    logic                       r_b2_draw;
    acr_pkg::t_side             r_b2_side;
    logic [acr_pkg::AccW-1:0]   r_b2_acc_b;
    logic [acr_pkg::AccW-1:0]   r_b2_acc_g;
    logic [acr_pkg::AccW-1:0]   r_b2_acc_r;

    logic                       r_done;
    logic [acr_pkg::ChanW-1:0]  r_out_b;
    logic [acr_pkg::ChanW-1:0]  r_out_g;
    logic [acr_pkg::ChanW-1:0]  r_out_r;

    logic [acr_pkg::RootW-1:0]  rr;
    logic [acr_pkg::RootW-1:0]  rim_gap;
    logic                       n_b1_draw;
    logic [acr_pkg::VW-1:0]     n_b1_v;

    always_comb begin
        rr      = acr_pkg::RootW'({i_cfg.radius, {(acr_pkg::WBits-acr_pkg::FracBits){1'b0}}});
        rim_gap = (i_bus.root >= rr) ? i_bus.root - rr : rr - i_bus.root;
        if (i_cfg.fill_mode && (i_bus.root <= rr)) begin
            n_b1_draw = i_bus.side.in_box;
            n_b1_v    = '0;
        end else begin
            n_b1_draw = i_bus.side.in_box && (rim_gap <= acr_pkg::RootW'(acr_pkg::OneW));
            n_b1_v    = rim_gap[acr_pkg::VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_b1_vld <= i_bus.vld;
            r_b2_vld <= r_b1_vld;
            r_done   <= r_b2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_draw  <= n_b1_draw;
        r_b1_v     <= n_b1_v;
        r_b1_side  <= i_bus.side;

        r_b2_draw  <= r_b1_draw;
        r_b2_side  <= r_b1_side;
        r_b2_acc_b <= mix(r_b1_v, r_b1_side.blue, i_cfg.color_blue);
        r_b2_acc_g <= mix(r_b1_v, r_b1_side.green, i_cfg.color_green);
        r_b2_acc_r <= mix(r_b1_v, r_b1_side.red, i_cfg.color_red);

        r_out_b    <= r_b2_draw ? round_sat(r_b2_acc_b) : r_b2_side.blue;
        r_out_g    <= r_b2_draw ? round_sat(r_b2_acc_g) : r_b2_side.green;
        r_out_r    <= r_b2_draw ? round_sat(r_b2_acc_r) : r_b2_side.red;
    end

    assign o_done      = r_done;
    assign o_out_blue  = r_out_b;
    assign o_out_green = r_out_g;
    assign o_out_red   = r_out_r;

endmodule

// ----- hdl/antialiased_circle_raster.sv -----
// antialiased_circle_raster: top level, configuration registers and pipeline
// depends on acr_pkg, acr_front, acr_sqrt, acr_blend

// Takes one pixel per clock whenever busy is low (busy is high only in reset
// and the cycle after) and returns its overlaid colour on o_done, in input
// order, once it has passed the front, square root and blend stages. The
// pipeline runs box test, squaring and summing, then the square root at three
// digits per stage, then weight, blend and output register. Results cannot be
// held off; configuration is accepted only while the pipeline is empty and
// start is low.

module antialiased_circle_raster (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [acr_pkg::CoordW-1:0]    i_pixel_x,
    input  logic [acr_pkg::CoordW-1:0]    i_pixel_y,
    input  logic [acr_pkg::ChanW-1:0]     i_in_blue,
    input  logic [acr_pkg::ChanW-1:0]     i_in_green,
    input  logic [acr_pkg::ChanW-1:0]     i_in_red,
    output logic                          o_done,
    output logic [acr_pkg::ChanW-1:0]     o_out_blue,
    output logic [acr_pkg::ChanW-1:0]     o_out_green,
    output logic [acr_pkg::ChanW-1:0]     o_out_red,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [acr_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [acr_pkg::CfgDataW-1:0]  i_cfg_data
);

    localparam int InFlightW = $clog2(acr_pkg::Latency + 1);

    acr_pkg::t_cfg        r_cfg;
    logic                 r_busy;
    logic [InFlightW-1:0] r_inflight;
    logic                 accept;
    logic                 cfg_write;
    acr_pkg::t_rad_bus    rad_bus;
    acr_pkg::t_root_bus   root_bus;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy && !start && (r_inflight == '0);
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_inflight <= '0;
            r_cfg      <= '0;
        end else begin
            r_busy <= 1'b0;
            if (accept && !o_done) begin
                r_inflight <= r_inflight + 1'b1;
            end else if (!accept && o_done) begin
                r_inflight <= r_inflight - 1'b1;
            end
            if (cfg_write) begin
                unique case (i_cfg_index)
                    acr_pkg::CfgCenterX:    r_cfg.center_x    <= i_cfg_data;
                    acr_pkg::CfgCenterY:    r_cfg.center_y    <= i_cfg_data;
                    acr_pkg::CfgRadius:     r_cfg.radius      <= i_cfg_data;
                    acr_pkg::CfgColorBlue:  r_cfg.color_blue  <= i_cfg_data[acr_pkg::ChanW-1:0];
                    acr_pkg::CfgColorGreen: r_cfg.color_green <= i_cfg_data[acr_pkg::ChanW-1:0];
                    acr_pkg::CfgColorRed:   r_cfg.color_red   <= i_cfg_data[acr_pkg::ChanW-1:0];
                    acr_pkg::CfgFillMode:   r_cfg.fill_mode   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    acr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_in_blue  (i_in_blue),
        .i_in_green (i_in_green),
        .i_in_red   (i_in_red),
        .i_cfg      (r_cfg),
        .o_bus      (rad_bus)
    );

    acr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bus   (rad_bus),
        .o_bus   (root_bus)
    );

    acr_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bus       (root_bus),
        .i_cfg       (r_cfg),
        .o_done      (o_done),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(acr_pkg::Latency) o_done)
        else $error("accepted pixel produced no result");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, acr_pkg::Latency))
        else $error("result without an accepted pixel");

    a_radius_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index == acr_pkg::CfgRadius))
        |=> (r_cfg.radius == $past(i_cfg_data)))
        else $error("radius write lost");

endmodule

// ----- bench/overlay_check_pkg.sv -----
// overlay_check_pkg: scoreboard for the circle overlay bench, holding its own copy
// of the overlay registers and predicting each pixel from it
// depends on acr_pkg

package overlay_check_pkg;

    localparam logic [acr_pkg::CfgIdxW-1:0] CfgNoRegister = 3'd7;

    typedef struct packed {
        logic [acr_pkg::ChanW-1:0] blue;
        logic [acr_pkg::ChanW-1:0] green;
        logic [acr_pkg::ChanW-1:0] red;
    } t_bgr;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= n) root = trial;
        end
        return root;
    endfunction

    class overlay_scoreboard;
        acr_pkg::t_cfg cfg;
        t_bgr          expected_pixels[$];
        int            mismatches;

        function new();
            cfg        = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [acr_pkg::CfgIdxW-1:0] idx,
                                     logic [acr_pkg::CfgDataW-1:0] data);
            case (idx)
                acr_pkg::CfgCenterX:    cfg.center_x    = data;
                acr_pkg::CfgCenterY:    cfg.center_y    = data;
                acr_pkg::CfgRadius:     cfg.radius      = data;
                acr_pkg::CfgColorBlue:  cfg.color_blue  = data[7:0];
                acr_pkg::CfgColorGreen: cfg.color_green = data[7:0];
                acr_pkg::CfgColorRed:   cfg.color_red   = data[7:0];
                acr_pkg::CfgFillMode:   cfg.fill_mode   = data[0];
                default: ;
            endcase
        endfunction

        // inclusive box span on one axis
        function bit within_span(int p, int c);
            int lo;
            int hi;
            lo = c - int'(cfg.radius);
            lo = (lo < 0) ? 0 : (lo >> acr_pkg::FracBits);
            hi = (c + int'(cfg.radius) + acr_pkg::FracMask) >> acr_pkg::FracBits;
            return (p >= lo) && (p <= hi);
        endfunction

        function longint unsigned axis_sq(int p, int c);
            longint unsigned a;
            longint unsigned m;
            a = longint'(p) << acr_pkg::FracBits;
            m = (a >= c) ? a - c : c - a;
            return m * m;
        endfunction

        function logic [7:0] mix(int pix, int col, int w);
            int s;
            s = (w * pix + (acr_pkg::OneW - w) * col + acr_pkg::OneW / 2) >> acr_pkg::WBits;
            return (s > 255) ? 8'd255 : s[7:0];
        endfunction

        function t_bgr overlay_pixel(int px, int py, t_bgr pix);
            longint unsigned radial;
            longint unsigned ring_r;
            longint unsigned w;
            t_bgr            o;
            o = pix;
            if (within_span(px, cfg.center_x) && within_span(py, cfg.center_y)) begin
                radial = int_sqrt((axis_sq(px, cfg.center_x) + axis_sq(py, cfg.center_y))
                                  << (2 * (acr_pkg::WBits - acr_pkg::FracBits)));
                ring_r = longint'(cfg.radius) << (acr_pkg::WBits - acr_pkg::FracBits);
                if (cfg.fill_mode && radial <= ring_r) w = 0;
                else w = (radial >= ring_r) ? radial - ring_r : ring_r - radial;
                if (w <= acr_pkg::OneW) begin
                    o.blue  = mix(pix.blue, cfg.color_blue, int'(w));
                    o.green = mix(pix.green, cfg.color_green, int'(w));
                    o.red   = mix(pix.red, cfg.color_red, int'(w));
                end
            end
            return o;
        endfunction

        function void note_pixel(int px, int py, t_bgr pix);
            t_bgr e;
            e = overlay_pixel(px, py, pix);
            expected_pixels = {expected_pixels, e};
        endfunction

        function void check_pixel(t_bgr got);
            t_bgr e;
            if (expected_pixels.size() == 0) begin
                $error("result with no pixel pending: out_blue %0d out_green %0d out_red %0d",
                       got.blue, got.green, got.red);
                mismatches++;
                return;
            end
            e = expected_pixels.pop_front();
            if (got.blue !== e.blue) begin
                $error("out_blue expected %0d actual %0d", e.blue, got.blue);
                mismatches++;
            end
            if (got.green !== e.green) begin
                $error("out_green expected %0d actual %0d", e.green, got.green);
                mismatches++;
            end
            if (got.red !== e.red) begin
                $error("out_red expected %0d actual %0d", e.red, got.red);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

endpackage

// ----- bench/tb.sv -----
// tb: directed and random pixel streams through the circle overlay, checked
// pixel by pixel against the scoreboard's prediction
// depends on acr_pkg, overlay_check_pkg and antialiased_circle_raster

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QuietLimit  = 1000;
    localparam int RandomItems = 1550;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [acr_pkg::CoordW-1:0]    i_pixel_x;
    logic [acr_pkg::CoordW-1:0]    i_pixel_y;
    logic [acr_pkg::ChanW-1:0]     i_in_blue;
    logic [acr_pkg::ChanW-1:0]     i_in_green;
    logic [acr_pkg::ChanW-1:0]     i_in_red;
    logic                          o_done;
    logic [acr_pkg::ChanW-1:0]     o_out_blue;
    logic [acr_pkg::ChanW-1:0]     o_out_green;
    logic [acr_pkg::ChanW-1:0]     o_out_red;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [acr_pkg::CfgIdxW-1:0]   i_cfg_index;
    logic [acr_pkg::CfgDataW-1:0]  i_cfg_data;

    overlay_check_pkg::overlay_scoreboard sb;
    int                quiet_cycles = 0;
    int                pixels_sent  = 0;

    antialiased_circle_raster dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_in_blue   (i_in_blue),
        .i_in_green  (i_in_green),
        .i_in_red    (i_in_red),
        .o_done      (o_done),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_pixel('{blue: o_out_blue, green: o_out_green, red: o_out_red});
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input int x, input int y, input logic [7:0] b,
                              input logic [7:0] g, input logic [7:0] r, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_pixel_x  = x[11:0];
        i_pixel_y  = y[11:0];
        i_in_blue  = b;
        i_in_green = g;
        i_in_red   = r;
        do @(posedge i_clk); while (busy);
        sb.note_pixel(x, y, '{blue: b, green: g, red: r});
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [acr_pkg::CfgIdxW-1:0] idx,
                             input logic [acr_pkg::CfgDataW-1:0] data);
        @(negedge i_clk);
        start       = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_circle(input int cx, input int cy, input int rad, input int fill);
        wait_drained();
        write_cfg(acr_pkg::CfgCenterX, cx[15:0]);
        write_cfg(acr_pkg::CfgCenterY, cy[15:0]);
        write_cfg(acr_pkg::CfgRadius, rad[15:0]);
        write_cfg(acr_pkg::CfgFillMode, fill[15:0]);
    endtask

    function automatic int edge_or_random16();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 0;
        if (pick == 1) return 16'hFFFF;
        return $urandom_range(0, 65535);
    endfunction

    function automatic int clamp_coord(int c);
        return (c < 0) ? 0 : (c > 4095) ? 4095 : c;
    endfunction

    task automatic run_random_phase(input int count);
        int cx, cy, rad, pick, gap_mode, gap;
        int r_px, cx_px, cy_px, dx, dy, base, t;
        cx = edge_or_random16();
        cy = edge_or_random16();
        pick = $urandom_range(0, 99);
        if (pick < 10) rad = $urandom_range(0, 15);
        else if (pick < 65) rad = $urandom_range(16, 400);
        else if (pick < 90) rad = $urandom_range(401, 5000);
        else if (pick < 95) rad = 16'hFFFF;
        else rad = $urandom_range(0, 65535);
        set_circle(cx, cy, rad, $urandom_range(0, 1));
        write_cfg(acr_pkg::CfgColorBlue, 16'(edge_or_random16()));
        write_cfg(acr_pkg::CfgColorGreen, 16'(edge_or_random16()));
        write_cfg(acr_pkg::CfgColorRed, 16'(edge_or_random16()));
        if ($urandom_range(0, 7) == 0) begin
            write_cfg(overlay_check_pkg::CfgNoRegister, 16'($urandom_range(0, 65535)));
        end
        r_px     = rad >> acr_pkg::FracBits;
        cx_px    = cx >> acr_pkg::FracBits;
        cy_px    = cy >> acr_pkg::FracBits;
        gap_mode = $urandom_range(0, 2);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // around the rim
                dx   = int'($urandom_range(0, 2 * r_px + 4)) - (r_px + 2);
                t    = r_px * r_px - dx * dx;
                base = (t > 0) ? int'(overlay_check_pkg::int_sqrt(t)) : 0;
                dy   = base + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1)) dy = -dy;
            end else if (pick < 75) begin
                dx = int'($urandom_range(0, 2 * r_px + 2)) - (r_px + 1);
                dy = int'($urandom_range(0, 2 * r_px + 2)) - (r_px + 1);
            end else begin
                dx = int'($urandom_range(0, 4095)) - cx_px;
                dy = int'($urandom_range(0, 4095)) - cy_px;
            end
            case (gap_mode)
                0: gap = 0;
                1: gap = $urandom_range(0, 15);
                default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
            endcase
            send_pixel(clamp_coord(cx_px + dx), clamp_coord(cy_px + dy),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), gap);
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
    endtask

    initial begin
        int n;
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_pixel_x   = '0;
        i_pixel_y   = '0;
        i_in_blue   = '0;
        i_in_green  = '0;
        i_in_red    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: zero radius ring at the origin
        send_pixel(0, 0, 8'd255, 8'd0, 8'd128, 0);
        send_pixel(1, 1, 8'd17, 8'd34, 8'd51, 0);

        // ring of radius 10 about (100, 100)
        set_circle(100 << 4, 100 << 4, 10 << 4, 0);
        write_cfg(acr_pkg::CfgColorBlue, 16'hFFC8);
        write_cfg(acr_pkg::CfgColorGreen, 16'h0032);
        write_cfg(acr_pkg::CfgColorRed, 16'h00FF);
        write_cfg(overlay_check_pkg::CfgNoRegister, 16'hFFFF);
        send_pixel(110, 100, 8'd0, 8'd0, 8'd0, 0);
        send_pixel(111, 100, 8'd255, 8'd255, 8'd255, 0);
        send_pixel(109, 100, 8'd1, 8'd2, 8'd3, 2);
        send_pixel(100, 90, 8'd255, 8'd0, 8'd255, 0);
        send_pixel(107, 107, 8'd0, 8'd255, 8'd0, 0);
        send_pixel(100, 100, 8'd77, 8'd88, 8'd99, 1);
        send_pixel(0, 0, 8'd5, 8'd6, 8'd7, 0);
        send_pixel(4095, 4095, 8'd250, 8'd251, 8'd252, 0);

        // filled disc
        set_circle(100 << 4, 100 << 4, 10 << 4, 1);
        send_pixel(100, 100, 8'd255, 8'd255, 8'd255, 0);
        send_pixel(105, 103, 8'd0, 8'd0, 8'd0, 0);
        send_pixel(111, 100, 8'd9, 8'd9, 8'd9, 0);
        send_pixel(110, 107, 8'd128, 8'd64, 8'd32, 0);

        // zero radius, whole and half unit centres
        set_circle(100 << 4, 100 << 4, 0, 1);
        send_pixel(100, 100, 8'd10, 8'd20, 8'd30, 0);
        send_pixel(101, 100, 8'd10, 8'd20, 8'd30, 0);
        set_circle((100 << 4) + 8, 100 << 4, 0, 0);
        send_pixel(100, 100, 8'd255, 8'd0, 8'd0, 0);
        send_pixel(101, 100, 8'd0, 8'd255, 8'd0, 0);
        set_circle((100 << 4) + 8, 100 << 4, 0, 1);
        send_pixel(100, 100, 8'd0, 8'd0, 8'd255, 0);

        // largest centre and radius cover the whole picture
        set_circle(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        write_cfg(acr_pkg::CfgColorBlue, 16'h0000);
        send_pixel(0, 0, 8'd255, 8'd255, 8'd255, 0);
        send_pixel(4095, 4095, 8'd0, 8'd0, 8'd0, 0);
        send_pixel(4095, 0, 8'd100, 8'd200, 8'd50, 0);
        set_circle(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_pixel(4095, 4095, 8'd255, 8'd0, 8'd255, 0);

        while (pixels_sent < RandomItems) begin
            n = $urandom_range(40, 120);
            run_random_phase(n);
            pixels_sent += n;
        end

        wait_drained();
        repeat (acr_pkg::Latency + 4) @(posedge i_clk);
        if (sb.pending() != 0) $error("%0d pixels never returned", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
